FILE: rtl/cps_pkg.sv
// Package for the clap pattern switch: register indexes, command codes,
// reset values and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package cps_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF  = 4;

    localparam int TIME_BITS  = 32;
    localparam int CFG_BITS   = 16;
    localparam int THR_BITS   = 12;
    localparam int CMP_BITS   = 16;
    localparam int CMD_BITS   = 3;
    localparam int BEEP_BITS  = 2;
    localparam int ADDR_BITS  = 2;

    localparam logic [THR_BITS-1:0] THRESHOLD_RST    = 12'd600;
    localparam logic [CFG_BITS-1:0] MIN_INTERVAL_RST = 16'd100;
    localparam logic [CFG_BITS-1:0] TIMEOUT_RST      = 16'd500;
    localparam logic [CFG_BITS-1:0] WINDOW_RST       = 16'd50;

    typedef enum logic [ADDR_BITS-1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_MIN_INTERVAL = 2'd1,
        REG_TIMEOUT      = 2'd2,
        REG_WINDOW       = 2'd3
    } cfg_reg_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_NONE    = 3'd0,
        CMD_LIGHT   = 3'd1,
        CMD_FAN     = 3'd2,
        CMD_ALL_OFF = 3'd3,
        CMD_UNKNOWN = 3'd4
    } cmd_t;

endpackage

FILE: rtl/clap_pattern_switch.sv
// Clap pattern switch: windowed peak-to-peak detector, clap counter and
// pattern executor. Depends on cps_pkg.
`timescale 1ns / 1ps

// Channel  | Dir | Word
// s_axis   | in  | tdata: sample, now_ms, zero pad
// m_axis   | out | tdata: level, pending_claps, command, light_state,
//          |     |        fan_state, beep_count, beep_short, zero pad
// cfg      | in  | cfg_addr = register index, cfg_data = value
//
// One word per cycle sustained. A word is first held in the input register,
// then the window/clap logic updates state; a window-closing word also loads
// the result register. Only such a word waits on a full, stalled result
// register; other words pass regardless of m_axis_tready.
// Reset sets detector state and config defaults, not data; no clearing pass.

module clap_pattern_switch #(
    parameter int SAMPLE_BITS = cps_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = cps_pkg::COUNT_BITS_DEF,
    localparam int IN_BITS    = SAMPLE_BITS + cps_pkg::TIME_BITS,
    localparam int IN_TDATA   = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = SAMPLE_BITS + COUNT_BITS + cps_pkg::CMD_BITS + 3
                                + cps_pkg::BEEP_BITS,
    localparam int OUT_TDATA  = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample, now_ms, zero pad
    input  logic [IN_TDATA-1:0]            s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // level, pending_claps, command, light_state, fan_state,
    // beep_count, beep_short, zero pad
    output logic [OUT_TDATA-1:0]           m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cps_pkg::ADDR_BITS-1:0]  cfg_addr,
    input  logic [cps_pkg::CFG_BITS-1:0]   cfg_data
);

    localparam int TB = cps_pkg::TIME_BITS;
    localparam int CB = cps_pkg::CMP_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration
    logic [cps_pkg::THR_BITS-1:0] threshold_reg;
    logic [cps_pkg::CFG_BITS-1:0] min_interval_reg;
    logic [cps_pkg::CFG_BITS-1:0] timeout_reg;
    logic [cps_pkg::CFG_BITS-1:0] window_reg;

    // input register
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic [TB-1:0]          in_now_reg;

    // detector state
    logic                   win_open_reg,   win_open_next;
    logic [TB-1:0]          win_start_reg,  win_start_next;
    logic [SAMPLE_BITS-1:0] win_max_reg,    win_max_next;
    logic [SAMPLE_BITS-1:0] win_min_reg,    win_min_next;
    logic [TB-1:0]          last_clap_reg,  last_clap_next;
    logic [COUNT_BITS-1:0]  count_reg,      count_next;
    logic                   pending_reg,    pending_next;
    logic                   light_reg,      light_next;
    logic                   fan_reg,        fan_next;

    // result register
    logic                         out_valid_reg,  out_valid_next;
    logic [SAMPLE_BITS-1:0]       out_level_reg;
    logic [COUNT_BITS-1:0]        out_claps_reg;
    cps_pkg::cmd_t                out_cmd_reg,    cmd_next;
    logic                         out_light_reg;
    logic                         out_fan_reg;
    logic [cps_pkg::BEEP_BITS-1:0] out_beeps_reg, beeps_next;
    logic                         out_short_reg,  short_next;

    logic                   accept;
    logic                   advance;
    logic                   emit;
    logic                   in_window;
    logic                   clap;
    logic                   execute;
    logic [TB-1:0]          elapsed;
    logic [TB-1:0]          since_clap;
    logic [SAMPLE_BITS-1:0] level;
    logic [COUNT_BITS-1:0]  shown;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= cps_pkg::THRESHOLD_RST;
            min_interval_reg <= cps_pkg::MIN_INTERVAL_RST;
            timeout_reg      <= cps_pkg::TIMEOUT_RST;
            window_reg       <= cps_pkg::WINDOW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cps_pkg::cfg_reg_t'(cfg_addr))
                cps_pkg::REG_THRESHOLD:    threshold_reg <= cfg_data[cps_pkg::THR_BITS-1:0];
                cps_pkg::REG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                cps_pkg::REG_TIMEOUT:      timeout_reg <= cfg_data;
                cps_pkg::REG_WINDOW:       window_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept || (in_valid_reg && !advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            in_now_reg    <= s_axis_tdata[IN_BITS-1:SAMPLE_BITS];
        end
    end

    assign elapsed    = in_now_reg - win_start_reg;
    assign since_clap = in_now_reg - last_clap_reg;
    assign in_window  = elapsed < TB'(window_reg);
    assign emit       = in_valid_reg && win_open_reg && !in_window;
    assign advance    = in_valid_reg && (!emit || !out_valid_reg || m_axis_tready);
    assign level      = (win_max_reg >= win_min_reg) ? (win_max_reg - win_min_reg)
                                                     : '0;
    assign clap       = (CB'(level) > CB'(threshold_reg))
                        && (since_clap > TB'(min_interval_reg));
    // a clap in this step leaves zero quiet time, so it never executes here
    assign execute    = pending_reg && !clap && (since_clap > TB'(timeout_reg));

    always_comb
    begin
        win_open_next  = win_open_reg;
        win_start_next = win_start_reg;
        win_max_next   = win_max_reg;
        win_min_next   = win_min_reg;
        last_clap_next = last_clap_reg;
        count_next     = count_reg;
        pending_next   = pending_reg;
        light_next     = light_reg;
        fan_next       = fan_reg;
        cmd_next       = cps_pkg::CMD_NONE;
        beeps_next     = '0;
        short_next     = 1'b0;
        shown          = count_reg;
        if (clap)
        begin
            shown = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        end
        if (advance)
        begin
            if (!win_open_reg || !in_window)
            begin
                win_open_next  = 1'b1;
                win_start_next = in_now_reg;
                win_max_next   = in_sample_reg;
                win_min_next   = in_sample_reg;
            end
            else
            begin
                if (in_sample_reg > win_max_reg)
                begin
                    win_max_next = in_sample_reg;
                end
                if (in_sample_reg < win_min_reg)
                begin
                    win_min_next = in_sample_reg;
                end
            end
            if (emit)
            begin
                if (clap)
                begin
                    count_next     = shown;
                    last_clap_next = in_now_reg;
                    pending_next   = 1'b1;
                end
                if (execute)
                begin
                    count_next   = '0;
                    pending_next = 1'b0;
                    if (count_reg == COUNT_BITS'(1))
                    begin
                        light_next = !light_reg;
                        cmd_next   = cps_pkg::CMD_LIGHT;
                        beeps_next = 2'd1;
                    end
                    else if (count_reg == COUNT_BITS'(2))
                    begin
                        fan_next   = !fan_reg;
                        cmd_next   = cps_pkg::CMD_FAN;
                        beeps_next = 2'd2;
                    end
                    else if (count_reg == COUNT_BITS'(3))
                    begin
                        light_next = 1'b0;
                        fan_next   = 1'b0;
                        cmd_next   = cps_pkg::CMD_ALL_OFF;
                        beeps_next = 2'd3;
                    end
                    else
                    begin
                        cmd_next   = cps_pkg::CMD_UNKNOWN;
                        beeps_next = 2'd1;
                        short_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_open_reg  <= 1'b0;
            win_start_reg <= '0;
            win_max_reg   <= '0;
            win_min_reg   <= '1;
            last_clap_reg <= '0;
            count_reg     <= '0;
            pending_reg   <= 1'b0;
            light_reg     <= 1'b0;
            fan_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_open_reg  <= win_open_next;
            win_start_reg <= win_start_next;
            win_max_reg   <= win_max_next;
            win_min_reg   <= win_min_next;
            last_clap_reg <= last_clap_next;
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            light_reg     <= light_next;
            fan_reg       <= fan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_level_reg <= level;
            out_claps_reg <= shown;
            out_cmd_reg   <= cmd_next;
            out_light_reg <= light_next;
            out_fan_reg   <= fan_next;
            out_beeps_reg <= beeps_next;
            out_short_reg <= short_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA'({out_short_reg, out_beeps_reg, out_fan_reg,
                                       out_light_reg, out_cmd_reg, out_claps_reg,
                                       out_level_reg});

endmodule

FILE: rtl/cps_checker.sv
// Port-level checks for the clap pattern switch, bound to the top level.
// Depends on cps_pkg and clap_pattern_switch.
`timescale 1ns / 1ps

module cps_checker #(
    parameter int SAMPLE_BITS = cps_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = cps_pkg::COUNT_BITS_DEF,
    localparam int OUT_BITS   = SAMPLE_BITS + COUNT_BITS + cps_pkg::CMD_BITS + 3
                                + cps_pkg::BEEP_BITS,
    localparam int OUT_TDATA  = ((OUT_BITS + 7) / 8) * 8
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_TDATA-1:0] m_axis_tdata
);

    localparam int CMD_LO   = SAMPLE_BITS + COUNT_BITS;
    localparam int LIGHT_AT = CMD_LO + cps_pkg::CMD_BITS;
    localparam int FAN_AT   = LIGHT_AT + 1;
    localparam int BEEP_LO  = FAN_AT + 1;
    localparam int SHORT_AT = BEEP_LO + cps_pkg::BEEP_BITS;

    logic [cps_pkg::CMD_BITS-1:0]  cmd;
    logic [cps_pkg::BEEP_BITS-1:0] beeps;

    assign cmd   = m_axis_tdata[LIGHT_AT-1:CMD_LO];
    assign beeps = m_axis_tdata[SHORT_AT-1:BEEP_LO];

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_beep_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[SHORT_AT] == (cmd == cps_pkg::CMD_UNKNOWN))
                          && ((beeps == '0) == (cmd == cps_pkg::CMD_NONE)))
        else $error("beep fields disagree with command");

    a_all_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (cmd == cps_pkg::CMD_ALL_OFF)
        |-> !m_axis_tdata[LIGHT_AT] && !m_axis_tdata[FAN_AT])
        else $error("all-off left a load on");

endmodule

bind clap_pattern_switch cps_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
) u_cps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/tb_clap_pattern_switch.sv
// Testbench for clap_pattern_switch: drives timestamped samples over the input
// stream; checks every result word against typed directed rows or a built-in
// window/clap predictor. Depends on cps_pkg and the clap_pattern_switch RTL.
`timescale 1ns / 1ps

module tb_clap_pattern_switch;

    localparam int SAMPLE_W     = 12;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 24;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 130;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SAMPLE_TOP   = 4095;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic [3:0]          claps;
        cps_pkg::cmd_t       command;
        logic                light;
        logic                fan;
        logic [1:0]          beeps;
        logic                beep_short;
    } switch_result_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NO_RESULT,
        ROW_RESULT
    } row_kind_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [31:0]         now_ms;
        row_kind_t           kind;
        switch_result_t      typed;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 16;

    // default settings: threshold 600, debounce 100, timeout 500, window 50
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{12'hFFF, 32'd1000,       ROW_NO_RESULT, '0},   // first sample opens window
        '{12'h000, 32'd1010,       ROW_NO_RESULT, '0},
        '{12'h800, 32'd1049,       ROW_NO_RESULT, '0},
        '{12'h064, 32'd1050,       ROW_RESULT,
          '{12'd4095, 4'd1, cps_pkg::CMD_NONE, 1'b0, 1'b0, 2'd0, 1'b0}},
        '{12'h064, 32'd1100,       ROW_RESULT,
          '{12'd0, 4'd1, cps_pkg::CMD_NONE, 1'b0, 1'b0, 2'd0, 1'b0}},
        '{12'h064, 32'd1700,       ROW_RESULT,
          '{12'd0, 4'd1, cps_pkg::CMD_LIGHT, 1'b1, 1'b0, 2'd1, 1'b0}},
        '{12'hFA0, 32'd1710,       ROW_PREDICT, '0},
        '{12'h000, 32'd1750,       ROW_PREDICT, '0},
        '{12'hFFF, 32'd1760,       ROW_PREDICT, '0},
        '{12'h000, 32'd1800,       ROW_PREDICT, '0},     // debounced clap
        '{12'hFFF, 32'd1820,       ROW_PREDICT, '0},
        '{12'h000, 32'd1860,       ROW_PREDICT, '0},
        '{12'h000, 32'd2400,       ROW_PREDICT, '0},     // two claps -> fan
        '{12'h7D0, 32'hFFFF_FFF0,  ROW_PREDICT, '0},
        '{12'h834, 32'h0000_0010,  ROW_PREDICT, '0},     // window spans time wrap
        '{12'hFFF, 32'h0000_0022,  ROW_PREDICT, '0}
    };

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [IN_TDATA_W-1:0]            s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [OUT_TDATA_W-1:0]           m_axis_tdata;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [cps_pkg::ADDR_BITS-1:0]    cfg_addr;
    logic [cps_pkg::CFG_BITS-1:0]     cfg_data;

    // predictor settings
    logic [cps_pkg::THR_BITS-1:0]     thr_cfg;
    logic [cps_pkg::CFG_BITS-1:0]     min_gap_cfg;
    logic [cps_pkg::CFG_BITS-1:0]     quiet_cfg;
    logic [cps_pkg::CFG_BITS-1:0]     win_cfg;

    // predictor state
    bit                      win_open;
    logic [31:0]             win_start;
    logic [SAMPLE_W-1:0]     win_hi;
    logic [SAMPLE_W-1:0]     win_lo;
    logic [31:0]             last_clap_ms;
    logic [3:0]              clap_cnt;
    bit                      claps_due;
    bit                      light_on;
    bit                      fan_on;

    switch_result_t          results_due[$];
    int                      mismatches;
    int                      samples_sent;
    int                      phase_items;
    int                      windows_closed;
    int                      patterns_run;
    int                      settings_used;
    int                      src_pct;
    int                      sink_pct;
    int                      cycle_count = 0;
    logic [31:0]             clock_ms;

    clap_pattern_switch dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit predict_window_close(input logic [SAMPLE_W-1:0] s,
                                                input logic [31:0] now,
                                                output switch_result_t r);
        logic [31:0] since;
        r = '0;
        if (!win_open)
        begin
            win_open  = 1'b1;
            win_start = now;
            win_hi    = s;
            win_lo    = s;
            return 1'b0;
        end
        since = now - win_start;
        if (since < {16'd0, win_cfg})
        begin
            if (s > win_hi)
                win_hi = s;
            if (s < win_lo)
                win_lo = s;
            return 1'b0;
        end
        r.level   = (win_hi >= win_lo) ? win_hi - win_lo : '0;
        win_start = now;
        win_hi    = s;
        win_lo    = s;
        since     = now - last_clap_ms;
        if (r.level > thr_cfg && since > {16'd0, min_gap_cfg})
        begin
            if (clap_cnt != 4'hF)
                clap_cnt = clap_cnt + 4'd1;
            last_clap_ms = now;
            claps_due    = 1'b1;
        end
        r.claps   = clap_cnt;
        r.command = cps_pkg::CMD_NONE;
        since     = now - last_clap_ms;
        if (claps_due && since > {16'd0, quiet_cfg})
        begin
            case (clap_cnt)
                4'd1:
                begin
                    light_on  = !light_on;
                    r.command = cps_pkg::CMD_LIGHT;
                    r.beeps   = 2'd1;
                end
                4'd2:
                begin
                    fan_on    = !fan_on;
                    r.command = cps_pkg::CMD_FAN;
                    r.beeps   = 2'd2;
                end
                4'd3:
                begin
                    light_on  = 1'b0;
                    fan_on    = 1'b0;
                    r.command = cps_pkg::CMD_ALL_OFF;
                    r.beeps   = 2'd3;
                end
                default:
                begin
                    r.command    = cps_pkg::CMD_UNKNOWN;
                    r.beeps      = 2'd1;
                    r.beep_short = 1'b1;
                end
            endcase
            clap_cnt  = '0;
            claps_due = 1'b0;
            patterns_run++;
        end
        r.light = light_on;
        r.fan   = fan_on;
        windows_closed++;
        return 1'b1;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [31:0] now,
                               input row_kind_t kind, input switch_result_t typed);
        switch_result_t predicted;
        bit             closed;
        s_axis_tdata  <= {4'd0, now, s};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        closed = predict_window_close(s, now, predicted);
        if (kind == ROW_PREDICT && closed)
            results_due.push_back(predicted);
        else if (kind == ROW_RESULT)
            results_due.push_back(typed);
        samples_sent++;
        phase_items++;
        if (src_pct != 0 && $urandom_range(1, 100) <= src_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic load_settings(input logic [cps_pkg::THR_BITS-1:0] thr,
                                 input logic [15:0] gap,
                                 input logic [15:0] quiet, input logic [15:0] win);
        logic [cps_pkg::CFG_BITS-1:0] vals [4];
        int                           i;
        // threshold register ignores its upper nibble
        vals[0] = {4'($urandom()), thr};
        vals[1] = gap;
        vals[2] = quiet;
        vals[3] = win;
        for (i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_addr  <= cps_pkg::cfg_reg_t'(i);
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (cps_pkg::cfg_reg_t'(i))
                cps_pkg::REG_THRESHOLD:    thr_cfg     = vals[i][cps_pkg::THR_BITS-1:0];
                cps_pkg::REG_MIN_INTERVAL: min_gap_cfg = vals[i];
                cps_pkg::REG_TIMEOUT:      quiet_cfg   = vals[i];
                cps_pkg::REG_WINDOW:       win_cfg     = vals[i];
                default:                   ;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // one window of samples starting at clock_ms; span is the time to the next window
    task automatic send_window(input bit loud, input bit borderline, input logic [31:0] span);
        int amp;
        int lo;
        int hi;
        int extras;
        lo = $urandom_range(0, SAMPLE_TOP);
        if (loud)
        begin
            amp = int'(thr_cfg) + (borderline ? 0 : 1);
            if (amp > SAMPLE_TOP)
                amp = SAMPLE_TOP;
            lo = $urandom_range(0, SAMPLE_TOP - amp);
            hi = borderline ? lo + amp : lo + $urandom_range(amp, SAMPLE_TOP - lo);
        end
        else
        begin
            hi = lo + $urandom_range(0, int'(thr_cfg) / 2);
            if (hi > SAMPLE_TOP)
                hi = SAMPLE_TOP;
        end
        send_sample(lo[SAMPLE_W-1:0], clock_ms, ROW_PREDICT, '0);
        if (win_cfg != 0)
        begin
            extras = $urandom_range(1, 3);
            send_sample(hi[SAMPLE_W-1:0], clock_ms + $urandom_range(0, win_cfg - 1),
                        ROW_PREDICT, '0);
            repeat (extras - 1)
                send_sample(SAMPLE_W'($urandom_range(lo, hi)),
                            clock_ms + $urandom_range(0, win_cfg - 1), ROW_PREDICT, '0);
        end
        clock_ms = clock_ms + span;
    endtask

    task automatic play_burst();
        int          roll;
        int          claps;
        logic [31:0] span;
        logic [31:0] floor_ms;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            repeat ($urandom_range(2, 6))
            begin
                clock_ms = $urandom();
                send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_TOP)), clock_ms,
                            ROW_PREDICT, '0);
            end
            return;
        end
        claps = (roll < 70) ? $urandom_range(1, 3) :
                (roll < 90) ? $urandom_range(4, 6) : $urandom_range(14, 18);
        repeat (claps)
        begin
            floor_ms = (min_gap_cfg > win_cfg) ? min_gap_cfg : win_cfg;
            if ($urandom_range(0, 99) < 85)
                span = min_gap_cfg + 1 + $urandom_range(0, 8);
            else
                span = $urandom_range(win_cfg, floor_ms);
            if (span < win_cfg)
                span = win_cfg;
            send_window(1'b1, $urandom_range(0, 9) == 0, span);
        end
        floor_ms = (quiet_cfg > win_cfg) ? quiet_cfg : win_cfg;
        if ($urandom_range(0, 99) < 80)
            span = quiet_cfg + 1 + $urandom_range(0, 10);
        else
            span = $urandom_range(win_cfg, floor_ms);
        if (span < win_cfg)
            span = win_cfg;
        send_window(1'b0, 1'b0, span);
    endtask

    initial
    begin
        int phase;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_addr      = cps_pkg::REG_THRESHOLD;
        cfg_data      = '0;
        thr_cfg       = cps_pkg::THRESHOLD_RST;
        min_gap_cfg   = cps_pkg::MIN_INTERVAL_RST;
        quiet_cfg     = cps_pkg::TIMEOUT_RST;
        win_cfg       = cps_pkg::WINDOW_RST;
        win_open      = 1'b0;
        win_start     = '0;
        win_hi        = '0;
        win_lo        = '1;
        last_clap_ms  = '0;
        clap_cnt      = '0;
        claps_due     = 1'b0;
        light_on      = 1'b0;
        fan_on        = 1'b0;
        src_pct       = 15;
        sink_pct      = 5;
        settings_used = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_sample(DIRECTED[i].sample, DIRECTED[i].now_ms, DIRECTED[i].kind,
                        DIRECTED[i].typed);
        s_axis_tvalid <= 1'b0;
        clock_ms = $urandom();

        for (phase = 0; phase < PHASES; phase++)
        begin
            while (results_due.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
            case (phase)
                0: load_settings(12'd1000, 16'd20, 16'd80, 16'd8);
                1: load_settings(12'd0, 16'd0, 16'd0, 16'd1);
                2: load_settings(12'd2000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: load_settings(12'd700, 16'd5, 16'd30, 16'd0);   // zero-length window
                4: load_settings(12'd4095, 16'($urandom_range(0, 60)),
                                 16'($urandom_range(0, 150)), 16'($urandom_range(1, 20)));
                7: load_settings(cps_pkg::THRESHOLD_RST, cps_pkg::MIN_INTERVAL_RST,
                                 cps_pkg::TIMEOUT_RST, cps_pkg::WINDOW_RST);
                default: load_settings(12'($urandom_range(200, 3500)),
                                       16'($urandom_range(0, 60)),
                                       16'($urandom_range(0, 150)),
                                       16'($urandom_range(1, 20)));
            endcase
            src_pct     = (phase == PHASES - 1) ? 0 : $urandom_range(0, 25);
            sink_pct    = (phase == PHASES - 1) ? 0 : $urandom_range(0, 10);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                play_burst();
            s_axis_tvalid <= 1'b0;
        end

        while (results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d samples across %0d register settings", samples_sent, settings_used);
        $display("Closed %0d windows and executed %0d clap patterns", windows_closed,
                 patterns_run);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_pct != 0 && $urandom_range(1, 100) <= sink_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        switch_result_t got;
        switch_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.level      = m_axis_tdata[11:0];
            got.claps      = m_axis_tdata[15:12];
            got.command    = cps_pkg::cmd_t'(m_axis_tdata[18:16]);
            got.light      = m_axis_tdata[19];
            got.fan        = m_axis_tdata[20];
            got.beeps      = m_axis_tdata[22:21];
            got.beep_short = m_axis_tdata[23];
            if (results_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word, expected none, got tdata=%h", $time,
                         m_axis_tdata);
            end
            else
            begin
                want = results_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    $display({"%0t: mismatch expected lvl=%0d claps=%0d cmd=%0d ",
                              "light=%0d fan=%0d beeps=%0d short=%0d, got lvl=%0d ",
                              "claps=%0d cmd=%0d light=%0d fan=%0d beeps=%0d short=%0d"},
                             $time, want.level, want.claps, want.command, want.light,
                             want.fan, want.beeps, want.beep_short, got.level,
                             got.claps, got.command, got.light, got.fan, got.beeps,
                             got.beep_short);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/cps_pkg.sv
rtl/clap_pattern_switch.sv
rtl/cps_checker.sv
dv/tb_clap_pattern_switch.sv
